FILE: src/assert_macros.svh
// assertion macros for the fraction accumulator alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define CHK_IMPL(label, clk, rst_n, a, c, msg)
`define CHK_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

FILE: src/fa_pkg.sv
// shared types and codes for the fraction accumulator alu
`default_nettype none
package fa_pkg;
  typedef enum logic [2:0] {
    OP_LOAD = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3, OP_DIV = 3'd4, OP_READ = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_GCD_START, ST_GCD_WAIT,
    ST_QN_START, ST_QN_WAIT, ST_QD_START, ST_QD_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: src/fraction_accumulator_alu_top.sv
// fraction accumulator alu top level: sequencer, shared multiplier and divider
// usage: pulse start with in_op, in_arg_num and in_arg_den while busy is low;
// the item transfers at that edge and busy rises. the op runs through three
// 32x32 products on one shared multiplier, one per cycle, then Euclid's gcd
// on the shared divider: a step issues one division and waits for its done,
// then two reducing divisions run on the same divider. a gcd takes up to
// about 45 steps; when both words are zero every division is skipped.
// the result appears on out_reduced_num, out_reduced_den and out_zero_gcd for
// exactly one cycle with out_valid high; busy falls in that same cycle, so
// the next start may transfer then.
// the receiver cannot stall the result.
// reset (rst_n low, synchronous) sets the accumulator to 0/1 and aborts any op.
// op codes six and seven behave as read only.
// a zero gcd (both words zero) returns the raw words with out_zero_gcd set.
// one item is worked on at a time.
`default_nettype none
`include "assert_macros.svh"
module fraction_accumulator_alu_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic signed [31:0] in_arg_num,
  input  wire logic signed [31:0] in_arg_den,
  output logic             out_valid,
  output logic signed [31:0] out_reduced_num,
  output logic signed [31:0] out_reduced_den,
  output logic             out_zero_gcd
);
  fa_pkg::state_t state_r, state_nxt;
  fa_pkg::div_req_t dreq;
  fa_pkg::div_rsp_t drsp;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, n_r, n_nxt, d_r, d_nxt, p_r, p_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic        valid_r, valid_nxt, zg_r, zg_nxt;

  fa_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign prod = ma * mb;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fa_pkg::ST_IDLE: if (start) state_nxt = fa_pkg::ST_MUL1;
      fa_pkg::ST_MUL1: state_nxt = fa_pkg::ST_MUL2;
      fa_pkg::ST_MUL2: state_nxt = fa_pkg::ST_MUL3;
      fa_pkg::ST_MUL3: state_nxt = fa_pkg::ST_GCD_START;
      fa_pkg::ST_GCD_START: begin
        if (y_r == 32'd0) state_nxt = (x_r == 32'd0) ? fa_pkg::ST_DONE : fa_pkg::ST_QN_START;
        else state_nxt = fa_pkg::ST_GCD_WAIT;
      end
      fa_pkg::ST_GCD_WAIT: if (drsp.done) state_nxt = fa_pkg::ST_GCD_START;
      fa_pkg::ST_QN_START: state_nxt = fa_pkg::ST_QN_WAIT;
      fa_pkg::ST_QN_WAIT: if (drsp.done) state_nxt = fa_pkg::ST_QD_START;
      fa_pkg::ST_QD_START: state_nxt = fa_pkg::ST_QD_WAIT;
      fa_pkg::ST_QD_WAIT: if (drsp.done) state_nxt = fa_pkg::ST_DONE;
      fa_pkg::ST_DONE: state_nxt = fa_pkg::ST_IDLE;
      default: state_nxt = fa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt = op_r; a_nxt = a_r; b_nxt = b_r; n_nxt = n_r; d_nxt = d_r; p_nxt = p_r;
    x_nxt = x_r; y_nxt = y_r; g_nxt = g_r; rn_nxt = rn_r; rd_nxt = rd_r;
    valid_nxt = 1'b0; zg_nxt = zg_r;
    dreq = '0;
    ma = n_r; mb = b_r;
    case (state_r)
      fa_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt = in_op;
          a_nxt = in_arg_num;
          b_nxt = (in_arg_den == 32'sd0) ? 32'd1 : in_arg_den;
        end
      end
      fa_pkg::ST_MUL1: begin
        ma = (op_r == fa_pkg::OP_MUL) ? a_r : b_r;
        mb = n_r;
        p_nxt = prod[31:0];
      end
      fa_pkg::ST_MUL2: begin
        ma = a_r; mb = d_r;
        case (op_r)
          fa_pkg::OP_ADD: p_nxt = p_r + prod[31:0];
          fa_pkg::OP_SUB: p_nxt = p_r - prod[31:0];
          default: p_nxt = p_r;
        endcase
      end
      fa_pkg::ST_MUL3: begin
        ma = d_r; mb = (op_r == fa_pkg::OP_DIV) ? a_r : b_r;
        case (op_r)
          fa_pkg::OP_LOAD: begin n_nxt = a_r; d_nxt = b_r; end
          fa_pkg::OP_ADD, fa_pkg::OP_SUB, fa_pkg::OP_MUL, fa_pkg::OP_DIV: begin
            n_nxt = p_r; d_nxt = prod[31:0];
          end
          default: ;
        endcase
        x_nxt = n_nxt; y_nxt = d_nxt;
      end
      fa_pkg::ST_GCD_START: begin
        if (y_r != 32'd0) begin
          dreq.start = 1'b1; dreq.dividend = x_r; dreq.divisor = y_r;
        end else begin
          g_nxt = x_r;
          zg_nxt = (x_r == 32'd0);
          rn_nxt = n_r; rd_nxt = d_r;
        end
      end
      fa_pkg::ST_GCD_WAIT: if (drsp.done) begin x_nxt = y_r; y_nxt = drsp.rem; end
      fa_pkg::ST_QN_START: begin dreq.start = 1'b1; dreq.dividend = n_r; dreq.divisor = g_r; end
      fa_pkg::ST_QN_WAIT: if (drsp.done) rn_nxt = drsp.quot;
      fa_pkg::ST_QD_START: begin dreq.start = 1'b1; dreq.dividend = d_r; dreq.divisor = g_r; end
      fa_pkg::ST_QD_WAIT: if (drsp.done) rd_nxt = drsp.quot;
      fa_pkg::ST_DONE: valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fa_pkg::ST_IDLE;
      n_r <= 32'd0;
      d_r <= 32'd1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      d_r <= d_nxt;
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt; a_r <= a_nxt; b_r <= b_nxt; p_r <= p_nxt; x_r <= x_nxt; y_r <= y_nxt;
    g_r <= g_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt; zg_r <= zg_nxt;
  end

  assign busy = (state_r != fa_pkg::ST_IDLE);
  assign out_valid = valid_r;
  assign out_reduced_num = rn_r;
  assign out_reduced_den = rd_r;
  assign out_zero_gcd = zg_r;

  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "transfer did not raise busy")
  `CHK_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy, "result while busy")
  `CHK_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid, "result held two cycles")
  `CHK_IMPL(a_zg_raw, clk, rst_n, out_valid && out_zero_gcd,
    out_reduced_num == 32'sd0 && out_reduced_den == 32'sd0, "zero gcd with nonzero words")
endmodule
`default_nettype wire

FILE: src/fa_divider.sv
// shared restoring signed divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module fa_divider (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fa_pkg::div_req_t req,
  output fa_pkg::div_rsp_t  rsp
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt, nneg_r, nneg_nxt, qneg_r, qneg_nxt;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; nneg_nxt = nneg_r; qneg_nxt = qneg_r;
    shifted = {r_r[30:0], q_r[31]};
    trial = {1'b0, shifted} - {1'b0, d_r};
    if (busy_r) begin
      if (r_r[31] || !trial[32]) begin
        r_nxt = r_r[31] ? shifted - d_r : trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = shifted;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      nneg_nxt = req.dividend[31];
      qneg_nxt = req.dividend[31] ^ req.divisor[31];
      q_nxt = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
      d_nxt = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
      r_nxt = 32'd0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; nneg_r <= nneg_nxt; qneg_r <= qneg_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    rsp.busy = busy_r;
    rsp.quot = qneg_r ? 32'd0 - q_r : q_r;
    rsp.rem  = nneg_r ? 32'd0 - r_r : r_r;
  end

  `CHK_NEXT(a_done_ends, clk, rst_n, done_r, !busy_r, "divider busy after done")
  `CHK_IMPL(a_cnt_live, clk, rst_n, busy_r, cnt_r != 6'd0, "divider count ran out")
  `CHK_IMPL(a_no_start_busy, clk, rst_n, busy_r, !done_r, "done while busy")
endmodule
`default_nettype wire

FILE: test/tb_fraction_accumulator_alu_top.sv
// testbench for the fraction accumulator alu: directed table plus random ops against a predictor
`default_nettype none
module tb_fraction_accumulator_alu_top;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] num;
    logic [31:0] den;
    bit          has_fixed;
    logic [31:0] fx_num;
    logic [31:0] fx_den;
    logic        fx_zero;
  } stim_row_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        zero;
  } fraction_t;

  localparam logic [31:0] MIN_INT = 32'h8000_0000;
  localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
  localparam logic [2:0]  OP_RSV6 = 3'd6;
  localparam logic [2:0]  OP_RSV7 = 3'd7;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_op;
  logic signed [31:0] in_arg_num;
  logic signed [31:0] in_arg_den;
  logic out_valid;
  logic signed [31:0] out_reduced_num;
  logic signed [31:0] out_reduced_den;
  logic out_zero_gcd;

  logic [31:0] acc_num;
  logic [31:0] acc_den;
  fraction_t reduced_q[$];
  int mismatches;
  bit idle_en;

  fraction_accumulator_alu_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_arg_num(in_arg_num), .in_arg_den(in_arg_den),
    .out_valid(out_valid), .out_reduced_num(out_reduced_num),
    .out_reduced_den(out_reduced_den), .out_zero_gcd(out_zero_gcd)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = magnitude(a) % magnitude(b);
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] trunc_quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // update the accumulator and return its reduced form
  function automatic fraction_t apply_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    logic [31:0] n;
    logic [31:0] d;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    fraction_t f;
    n = acc_num;
    d = acc_den;
    if (b == 32'd0) b = 32'd1;
    case (op)
      fa_pkg::OP_LOAD: begin
        n = a;
        d = b;
      end
      fa_pkg::OP_ADD: begin
        n = n * b + a * d;
        d = d * b;
      end
      fa_pkg::OP_SUB: begin
        n = n * b - a * d;
        d = d * b;
      end
      fa_pkg::OP_MUL: begin
        n = n * a;
        d = d * b;
      end
      fa_pkg::OP_DIV: begin
        n = n * b;
        d = d * a;
      end
      default: ;
    endcase
    acc_num = n;
    acc_den = d;
    x = n;
    y = d;
    while (y != 32'd0) begin
      z = trunc_rem(x, y);
      x = y;
      y = z;
    end
    if (x == 32'd0) begin
      f.num = n;
      f.den = d;
      f.zero = 1'b1;
    end else begin
      f.num = trunc_quot(n, x);
      f.den = trunc_quot(d, x);
      f.zero = 1'b0;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", out_reduced_num,
                                       out_reduced_den);
      end else begin
        fraction_t e;
        e = reduced_q.pop_front();
        if (out_reduced_num !== e.num || out_reduced_den !== e.den ||
            out_zero_gcd !== e.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d z%0b, got %0d/%0d z%0b",
                     $signed(e.num), $signed(e.den), e.zero,
                     out_reduced_num, out_reduced_den, out_zero_gcd);
        end
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [31:0] a, logic [31:0] b, bit has_fixed,
                           fraction_t fixed);
    fraction_t f;
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_arg_num <= a;
    in_arg_den <= b;
    do @(posedge clk); while (busy);
    f = apply_op(op, a, b);
    if (has_fixed) begin
      // fixed values typed in the table replace the predictor's result, which is not compared with them
      f.num = fixed.num;
      f.den = fixed.den;
      f.zero = fixed.zero;
    end
    reduced_q.push_back(f);
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20) - 10;
      2: return MIN_INT + $urandom_range(0, 2);
      3: return MAX_INT - $urandom_range(0, 2);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  stim_row_t table_rows[] = '{
    '{fa_pkg::OP_READ, 32'd0, 32'd0, 1'b1, 32'd0, 32'd1, 1'b0},
    '{fa_pkg::OP_LOAD, 32'd6, 32'd4, 1'b1, 32'd3, 32'd2, 1'b0},
    '{fa_pkg::OP_LOAD, 32'd5, 32'd0, 1'b1, 32'd5, 32'd1, 1'b0},
    '{fa_pkg::OP_ADD, 32'd1, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_SUB, 32'd3, 32'd4, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_MUL, -32'sd7, 32'd3, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_DIV, 32'd5, -32'sd2, 1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_RSV6, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'd0, 32'd0, 1'b0},
    '{OP_RSV7, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_LOAD, 32'd0, 32'd0, 1'b1, 32'd0, 32'd1, 1'b0},
    '{fa_pkg::OP_DIV, 32'd0, 32'd1, 1'b1, 32'd0, 32'd0, 1'b1},
    '{fa_pkg::OP_READ, 32'd9, 32'd9, 1'b1, 32'd0, 32'd0, 1'b1},
    '{fa_pkg::OP_LOAD, 32'd0, 32'd7, 1'b1, 32'd0, 32'd1, 1'b0},
    '{fa_pkg::OP_LOAD, 32'd3, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_DIV, 32'd0, 32'd5, 1'b1, 32'd1, 32'd0, 1'b0},
    '{fa_pkg::OP_LOAD, MIN_INT, 32'hffff_ffff, 1'b1, MIN_INT, 32'd1, 1'b0},
    '{fa_pkg::OP_LOAD, MIN_INT, MIN_INT, 1'b1, 32'd1, 32'd1, 1'b0},
    '{fa_pkg::OP_LOAD, MAX_INT, MAX_INT, 1'b1, 32'd1, 32'd1, 1'b0},
    '{fa_pkg::OP_MUL, MAX_INT, MIN_INT, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_LOAD, MIN_INT, 32'd1, 1'b1, MIN_INT, 32'd1, 1'b0},
    '{fa_pkg::OP_ADD, MIN_INT, MAX_INT, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_LOAD, -32'sd4, -32'sd6, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_SUB, 32'hffff_ffff, MIN_INT, 1'b0, 32'd0, 32'd0, 1'b0},
    '{fa_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'd0, 32'd0, 1'b0}
  };

  initial begin
    fraction_t fixed;
    logic [2:0] op;
    int unsigned k;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = fa_pkg::OP_READ;
    in_arg_num = '0;
    in_arg_den = '0;
    mismatches = 0;
    idle_en = 1'b1;
    acc_num = 32'd0;
    acc_den = 32'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      fixed.num = table_rows[i].fx_num;
      fixed.den = table_rows[i].fx_den;
      fixed.zero = table_rows[i].fx_zero;
      send_item(table_rows[i].op, table_rows[i].num, table_rows[i].den,
                table_rows[i].has_fixed, fixed);
    end
    for (k = 0; k < 400; k++) begin
      if (k >= 340) idle_en = 1'b0;
      // reload often so values stay small and gcd chains stay varied
      op = ($urandom_range(0, 4) == 0) ? fa_pkg::OP_LOAD : 3'($urandom_range(0, 7));
      send_item(op, rand_word(), rand_word(), 1'b0, fixed);
    end
    repeat (3000) begin
      if (reduced_q.size() == 0) break;
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
